### rtl/core/id_compaction_relabel_table_top_assert.svh
// assertion macros used by the relabel table back end rtl
`ifndef ID_COMPACTION_RELABEL_TABLE_TOP_ASSERT_SVH
`define ID_COMPACTION_RELABEL_TABLE_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define CRT_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CRT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/crt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int ID_W  = 16;
   localparam int LOC_W = 16;
   localparam int FWD_W = LOC_W + 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_MAP     = 2'd1,
      ACT_REVERSE = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   // classified request as it travels to the back end
   typedef struct packed {
      action_type       action;
      logic [ID_W-1:0]  id_a;
      logic [ID_W-1:0]  id_b;
      logic             a_ok;
      logic             b_ok;
      logic             batch_end;
   } cmd_type;

   // global id falls inside the forward table
   function automatic logic id_in_range(input logic [ID_W-1:0] id);
      return 32'(id) < 32'(TABLE_DEPTH);
   endfunction

endpackage

`default_nettype wire

### rtl/core/crt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module crt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/crt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module crt_front (
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_action,
   input  wire logic [crt_pkg::ID_W-1:0]  req_id_a,
   input  wire logic [crt_pkg::ID_W-1:0]  req_id_b,
   input  wire logic                      req_batch_end,
   input  wire logic                      q_full,
   input  wire logic                      init_busy,
   output logic                           push,
   output crt_pkg::cmd_type               push_cmd
);

   crt_pkg::action_type act;

   // take a request whenever the queue has room and the table is usable
   assign req_ready = !q_full && !init_busy;
   assign push      = req_valid && req_ready;
   assign act       = crt_pkg::action_type'(req_action);

   // classify the request and range check the ids it looks up
   always_comb begin
      push_cmd           = '0;
      push_cmd.action    = act;
      push_cmd.id_a      = req_id_a;
      push_cmd.id_b      = req_id_b;
      push_cmd.batch_end = req_batch_end;
      unique case (act)
         crt_pkg::ACT_INSERT: begin
            push_cmd.a_ok = crt_pkg::id_in_range(req_id_a);
         end
         crt_pkg::ACT_MAP: begin
            push_cmd.a_ok = crt_pkg::id_in_range(req_id_a);
            push_cmd.b_ok = crt_pkg::id_in_range(req_id_b);
         end
         crt_pkg::ACT_REVERSE: begin
            push_cmd.a_ok = 1'b1;
         end
         crt_pkg::ACT_CLEAR: begin
            push_cmd.a_ok = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/crt_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module crt_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire crt_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  q_valid,
   output logic                  q_full,
   output crt_pkg::cmd_type      q_cmd
);

   localparam int DEPTH  = crt_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QCNT_W = $clog2(DEPTH + 1);

   crt_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign q_valid = (cnt_ff != '0);
   assign q_full  = (cnt_ff == QCNT_W'(DEPTH));
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/core/crt_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "id_compaction_relabel_table_top_assert.svh"

module crt_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  wire crt_pkg::cmd_type           q_cmd,
   output logic                            pop,
   output logic                            init_busy,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [crt_pkg::LOC_W-1:0]       rsp_value_a,
   output logic [crt_pkg::LOC_W-1:0]       rsp_value_b,
   output logic                            rsp_newly_added,
   output logic                            rsp_invalid,
   output logic [crt_pkg::CNT_W-1:0]       rsp_item_count,
   output logic                            rsp_batch_end_out
);

   localparam int ADDR_W      = crt_pkg::ADDR_W;
   localparam int CNT_W       = crt_pkg::CNT_W;
   localparam int LOC_W       = crt_pkg::LOC_W;
   localparam int ID_W        = crt_pkg::ID_W;
   localparam int FWD_W       = crt_pkg::FWD_W;
   localparam int TABLE_DEPTH = crt_pkg::TABLE_DEPTH;

   typedef enum logic [6:0] {
      ST_INIT = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_INS  = 7'b0000100,
      ST_MAPA = 7'b0001000,
      ST_MAPB = 7'b0010000,
      ST_REV  = 7'b0100000,
      ST_CLR  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   idx_next;
   crt_pkg::cmd_type   cur_ff, cur_in;
   logic [LOC_W-1:0]   a_val_ff, a_val_in;
   logic               a_bad_ff, a_bad_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LOC_W-1:0]   rsp_value_a_ff, rsp_value_a_in;
   logic [LOC_W-1:0]   rsp_value_b_ff, rsp_value_b_in;
   logic               rsp_newly_added_ff, rsp_newly_added_in;
   logic               rsp_invalid_ff, rsp_invalid_in;
   logic [CNT_W-1:0]   rsp_item_count_ff, rsp_item_count_in;
   logic               rsp_batch_end_ff, rsp_batch_end_in;

   logic               slot_free, respond, b_hit;

   // forward table: present bit over local id
   logic               fwd_wr_en, fwd_rd_en;
   logic [ADDR_W-1:0]  fwd_wr_addr, fwd_rd_addr;
   logic [FWD_W-1:0]   fwd_wr_data, fwd_rd_data;

   // reverse table: global id per local id
   logic               rev_wr_en, rev_rd_en;
   logic [ADDR_W-1:0]  rev_wr_addr, rev_rd_addr;
   logic [ID_W-1:0]    rev_wr_data, rev_rd_data;

   crt_ram #(.WIDTH(FWD_W), .DEPTH(TABLE_DEPTH)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (fwd_wr_en),
      .wr_addr (fwd_wr_addr),
      .wr_data (fwd_wr_data),
      .rd_en   (fwd_rd_en),
      .rd_addr (fwd_rd_addr),
      .rd_data (fwd_rd_data)
   );

   crt_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_rev_ram (
      .clock   (clock),
      .wr_en   (rev_wr_en),
      .wr_addr (rev_wr_addr),
      .wr_data (rev_wr_data),
      .rd_en   (rev_rd_en),
      .rd_addr (rev_rd_addr),
      .rd_data (rev_rd_data)
   );

   // a new command starts only when the result register is free by then
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign init_busy = (state_ff == ST_INIT);
   assign idx_next  = idx_ff + 1'b1;
   assign b_hit     = cur_ff.b_ok && fwd_rd_data[FWD_W-1];

   // command sequencer
   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      idx_in             = idx_ff;
      cur_in             = cur_ff;
      a_val_in           = a_val_ff;
      a_bad_in           = a_bad_ff;
      pop                = 1'b0;
      respond            = 1'b0;
      rsp_value_a_in     = '0;
      rsp_value_b_in     = '0;
      rsp_newly_added_in = 1'b0;
      rsp_invalid_in     = 1'b0;
      rsp_batch_end_in   = cur_ff.batch_end;
      fwd_wr_en          = 1'b0;
      fwd_wr_addr        = ADDR_W'(idx_ff);
      fwd_wr_data        = '0;
      fwd_rd_en          = 1'b0;
      fwd_rd_addr        = ADDR_W'(cur_ff.id_b);
      rev_wr_en          = 1'b0;
      rev_wr_addr        = ADDR_W'(count_ff);
      rev_wr_data        = cur_ff.id_a;
      rev_rd_en          = 1'b0;
      rev_rd_addr        = ADDR_W'(idx_next);

      unique case (state_ff)
         // empty every forward entry once after reset
         ST_INIT: begin
            fwd_wr_en = 1'b1;
            if (idx_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end

         // pick up the next command and issue its first read, or respond at once if none is needed
         ST_IDLE: begin
            if (q_valid && slot_free) begin
               pop              = 1'b1;
               cur_in           = q_cmd;
               rsp_batch_end_in = q_cmd.batch_end;
               unique case (q_cmd.action)
                  crt_pkg::ACT_INSERT: begin
                     if (q_cmd.a_ok) begin
                        fwd_rd_en   = 1'b1;
                        fwd_rd_addr = ADDR_W'(q_cmd.id_a);
                        state_in    = ST_INS;
                     end else begin
                        respond        = 1'b1;
                        rsp_invalid_in = 1'b1;
                     end
                  end
                  crt_pkg::ACT_MAP: begin
                     fwd_rd_en   = 1'b1;
                     fwd_rd_addr = ADDR_W'(q_cmd.id_a);
                     state_in    = ST_MAPA;
                  end
                  crt_pkg::ACT_REVERSE: begin
                     if (32'(q_cmd.id_a) < 32'(count_ff)) begin
                        rev_rd_en   = 1'b1;
                        rev_rd_addr = ADDR_W'(q_cmd.id_a);
                        state_in    = ST_REV;
                     end else begin
                        respond        = 1'b1;
                        rsp_invalid_in = 1'b1;
                     end
                  end
                  crt_pkg::ACT_CLEAR: begin
                     if (count_ff == '0) begin
                        respond = 1'b1;
                     end else begin
                        rev_rd_en   = 1'b1;
                        rev_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = ST_CLR;
                     end
                  end
               endcase
            end
         end

         // insert: hit, full table or fresh assignment
         ST_INS: begin
            respond  = 1'b1;
            state_in = ST_IDLE;
            if (fwd_rd_data[FWD_W-1]) begin
               rsp_value_a_in = fwd_rd_data[LOC_W-1:0];
            end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
               rsp_invalid_in = 1'b1;
            end else begin
               fwd_wr_en          = 1'b1;
               fwd_wr_addr        = ADDR_W'(cur_ff.id_a);
               fwd_wr_data        = {1'b1, LOC_W'(count_ff)};
               rev_wr_en          = 1'b1;
               count_in           = count_ff + 1'b1;
               rsp_value_a_in     = LOC_W'(count_ff);
               rsp_newly_added_in = 1'b1;
            end
         end

         // map: keep source result, look up destination
         ST_MAPA: begin
            if (cur_ff.a_ok && fwd_rd_data[FWD_W-1]) begin
               a_val_in = fwd_rd_data[LOC_W-1:0];
               a_bad_in = 1'b0;
            end else begin
               a_val_in = '0;
               a_bad_in = 1'b1;
            end
            fwd_rd_en   = 1'b1;
            fwd_rd_addr = ADDR_W'(cur_ff.id_b);
            state_in    = ST_MAPB;
         end

         ST_MAPB: begin
            respond        = 1'b1;
            state_in       = ST_IDLE;
            rsp_value_a_in = a_val_ff;
            rsp_value_b_in = b_hit ? fwd_rd_data[LOC_W-1:0] : '0;
            rsp_invalid_in = a_bad_ff || !b_hit;
         end

         ST_REV: begin
            respond        = 1'b1;
            state_in       = ST_IDLE;
            rsp_value_a_in = rev_rd_data;
         end

         // clear: one assigned entry per cycle, next reverse read overlapped
         ST_CLR: begin
            if (crt_pkg::id_in_range(rev_rd_data)) begin
               fwd_wr_en   = 1'b1;
               fwd_wr_addr = ADDR_W'(rev_rd_data);
            end
            if (idx_next == count_ff) begin
               count_in = '0;
               respond  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rev_rd_en = 1'b1;
               idx_in    = idx_next;
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase

      rsp_item_count_in = count_in;

      // result register: load on respond, drain on acceptance
      if (respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      a_val_ff <= a_val_in;
      a_bad_ff <= a_bad_in;
      if (respond) begin
         rsp_value_a_ff     <= rsp_value_a_in;
         rsp_value_b_ff     <= rsp_value_b_in;
         rsp_newly_added_ff <= rsp_newly_added_in;
         rsp_invalid_ff     <= rsp_invalid_in;
         rsp_item_count_ff  <= rsp_item_count_in;
         rsp_batch_end_ff   <= rsp_batch_end_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_a       = rsp_value_a_ff;
   assign rsp_value_b       = rsp_value_b_ff;
   assign rsp_newly_added   = rsp_newly_added_ff;
   assign rsp_invalid       = rsp_invalid_ff;
   assign rsp_item_count    = rsp_item_count_ff;
   assign rsp_batch_end_out = rsp_batch_end_ff;

   // checks
   `CRT_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_DEPTH), "count past table depth")
   `CRT_ASSERT_IMPLIES(a_walk_below, clock, reset, state_ff == ST_CLR, idx_ff < count_ff, "clear walk past count")
   `CRT_ASSERT_NEXT(a_fresh_bump, clock, reset, !reset && respond && rsp_newly_added_in, count_ff == $past(count_ff) + 1'b1, "fresh insert without count bump")
   `CRT_ASSERT_IMPLIES(a_init_quiet, clock, reset, state_ff == ST_INIT, !pop && !respond, "command handled during clearing pass")
   `CRT_ASSERT_IMPLIES(a_slot_free, clock, reset, respond, !rsp_valid_ff || rsp_ready, "result overwrites a pending result")

endmodule

`default_nettype wire

### rtl/core/id_compaction_relabel_table_top.sv
// a request passes the front classifier into the command queue; the back end pops
// it, reads the tables and loads the result register. map reads the forward table
// twice, and clear walks every assigned entry. throughput is bounded by the single
// read port of each table memory: the back end finishes one command before it pops the next.
// reset: synchronous; req_ready stays low while the forward table is swept empty,
// one entry per cycle; count and queue reset to empty.
`timescale 1ns / 1ps
`default_nettype none

module id_compaction_relabel_table_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_action,
   input  wire logic [crt_pkg::ID_W-1:0]  req_id_a,
   input  wire logic [crt_pkg::ID_W-1:0]  req_id_b,
   input  wire logic                      req_batch_end,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [crt_pkg::LOC_W-1:0]      rsp_value_a,
   output logic [crt_pkg::LOC_W-1:0]      rsp_value_b,
   output logic                           rsp_newly_added,
   output logic                           rsp_invalid,
   output logic [crt_pkg::CNT_W-1:0]      rsp_item_count,
   output logic                           rsp_batch_end_out
);

   logic              push, pop, q_valid, q_full, init_busy;
   crt_pkg::cmd_type  push_cmd, q_cmd;

   // request intake and classification
   crt_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_id_a      (req_id_a),
      .req_id_b      (req_id_b),
      .req_batch_end (req_batch_end),
      .q_full        (q_full),
      .init_busy     (init_busy),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   // decoupling queue
   crt_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .q_cmd    (q_cmd)
   );

   // table execution and result register
   crt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (q_cmd),
      .pop               (pop),
      .init_busy         (init_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_a       (rsp_value_a),
      .rsp_value_b       (rsp_value_b),
      .rsp_newly_added   (rsp_newly_added),
      .rsp_invalid       (rsp_invalid),
      .rsp_item_count    (rsp_item_count),
      .rsp_batch_end_out (rsp_batch_end_out)
   );

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

   // longest correct quiet stretch is the forward table sweep after reset
   localparam int STALL_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int SEGMENTS    = 12;
   localparam int SEG_ITEMS   = 150;

   typedef struct packed {
      logic [crt_pkg::LOC_W-1:0] value_a;
      logic [crt_pkg::LOC_W-1:0] value_b;
      logic                      newly_added;
      logic                      invalid;
      logic [crt_pkg::CNT_W-1:0] item_count;
      logic                      batch_end;
   } relabel_result_type;

   // predicts the table and checks each response against the oldest prediction
   class relabel_scoreboard_type;
      bit [crt_pkg::LOC_W-1:0] local_of [crt_pkg::TABLE_DEPTH];
      bit [crt_pkg::ID_W-1:0]  global_of [crt_pkg::TABLE_DEPTH];
      bit                      present_tbl [crt_pkg::TABLE_DEPTH];
      int unsigned             assigned;
      relabel_result_type      due_results[$];
      int                      errors;

      function new();
         assigned = 0;
         errors   = 0;
         foreach (present_tbl[i]) present_tbl[i] = 1'b0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // forward lookup, absent or out of table reads zero
      function bit lookup(logic [crt_pkg::ID_W-1:0] gid,
                          output logic [crt_pkg::LOC_W-1:0] loc);
         loc = '0;
         if (32'(gid) >= crt_pkg::TABLE_DEPTH || !present_tbl[gid]) return 1'b0;
         loc = local_of[gid];
         return 1'b1;
      endfunction

      function void note_request(crt_pkg::action_type act, logic [crt_pkg::ID_W-1:0] a,
                                 logic [crt_pkg::ID_W-1:0] b, logic be);
         relabel_result_type e;
         int unsigned        i;
         e = '0;
         e.batch_end = be;
         case (act)
            crt_pkg::ACT_INSERT: begin
               if (32'(a) >= crt_pkg::TABLE_DEPTH) begin
                  e.invalid = 1'b1;
               end else if (present_tbl[a]) begin
                  e.value_a = local_of[a];
               end else if (assigned >= crt_pkg::TABLE_DEPTH) begin
                  e.invalid = 1'b1;
               end else begin
                  e.value_a           = crt_pkg::LOC_W'(assigned);
                  present_tbl[a]      = 1'b1;
                  local_of[a]         = crt_pkg::LOC_W'(assigned);
                  global_of[assigned] = a;
                  assigned++;
                  e.newly_added = 1'b1;
               end
            end
            crt_pkg::ACT_MAP: begin
               if (!lookup(a, e.value_a)) e.invalid = 1'b1;
               if (!lookup(b, e.value_b)) e.invalid = 1'b1;
            end
            crt_pkg::ACT_REVERSE: begin
               if (32'(a) < assigned && 32'(a) < crt_pkg::TABLE_DEPTH)
                  e.value_a = global_of[a];
               else e.invalid = 1'b1;
            end
            default: begin
               // walk assigned entries and drop their forward valid bits
               for (i = 0; i < assigned && i < crt_pkg::TABLE_DEPTH; i++)
                  present_tbl[global_of[i]] = 1'b0;
               assigned = 0;
            end
         endcase
         e.item_count = crt_pkg::CNT_W'(assigned);
         due_results.push_back(e);
      endfunction

      function void check_result(relabel_result_type got);
         relabel_result_type e;
         if (due_results.size() == 0) begin
            flag($sformatf("unexpected response va=%h vb=%h new=%b inv=%b cnt=%h be=%b",
                           got.value_a, got.value_b, got.newly_added, got.invalid,
                           got.item_count, got.batch_end));
            return;
         end
         e = due_results.pop_front();
         if (got.value_a !== e.value_a || got.value_b !== e.value_b ||
             got.newly_added !== e.newly_added || got.invalid !== e.invalid ||
             got.item_count !== e.item_count || got.batch_end !== e.batch_end)
            flag($sformatf({"mismatch exp va=%h vb=%h new=%b inv=%b cnt=%h be=%b",
                            " got va=%h vb=%h new=%b inv=%b cnt=%h be=%b"},
                           e.value_a, e.value_b, e.newly_added, e.invalid,
                           e.item_count, e.batch_end,
                           got.value_a, got.value_b, got.newly_added, got.invalid,
                           got.item_count, got.batch_end));
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void close_out();
         if (due_results.size() != 0)
            flag($sformatf("%0d responses never arrived", due_results.size()));
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [1:0]                    req_action;
   logic [crt_pkg::ID_W-1:0]      req_id_a;
   logic [crt_pkg::ID_W-1:0]      req_id_b;
   logic                          req_batch_end;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [crt_pkg::LOC_W-1:0]     rsp_value_a;
   logic [crt_pkg::LOC_W-1:0]     rsp_value_b;
   logic                          rsp_newly_added;
   logic                          rsp_invalid;
   logic [crt_pkg::CNT_W-1:0]     rsp_item_count;
   logic                          rsp_batch_end_out;

   relabel_scoreboard_type        sb;
   int                            req_gap_max = 14;
   int                            rsp_gap_max = 14;
   bit                            hold_rsp    = 1'b0;
   logic [crt_pkg::ID_W-1:0]      id_pool [64];

   id_compaction_relabel_table_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_id_a          (req_id_a),
      .req_id_b          (req_id_b),
      .req_batch_end     (req_batch_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_a       (rsp_value_a),
      .rsp_value_b       (rsp_value_b),
      .rsp_newly_added   (rsp_newly_added),
      .rsp_invalid       (rsp_invalid),
      .rsp_item_count    (rsp_item_count),
      .rsp_batch_end_out (rsp_batch_end_out)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // offer one request after a random gap and wait for it to be taken
   task automatic send_req(input crt_pkg::action_type act,
                           input logic [crt_pkg::ID_W-1:0] a,
                           input logic [crt_pkg::ID_W-1:0] b, input logic be);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_id_a      <= a;
      req_id_b      <= b;
      req_batch_end <= be;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(act, a, b, be);
   endtask

   // mostly ids from a small pool so that inserts and maps hit
   function automatic logic [crt_pkg::ID_W-1:0] pick_id();
      if ($urandom_range(0, 3) != 0) return id_pool[$urandom_range(0, 63)];
      return crt_pkg::ID_W'($urandom);
   endfunction

   task automatic send_random();
      int                       r;
      crt_pkg::action_type      act;
      logic [crt_pkg::ID_W-1:0] a;
      logic [crt_pkg::ID_W-1:0] b;
      r = $urandom_range(0, 99);
      if (r < 40) act = crt_pkg::ACT_INSERT;
      else if (r < 72) act = crt_pkg::ACT_MAP;
      else if (r < 97) act = crt_pkg::ACT_REVERSE;
      else act = crt_pkg::ACT_CLEAR;
      a = pick_id();
      b = pick_id();
      // reverse indexes mostly around the current count
      if (act == crt_pkg::ACT_REVERSE && $urandom_range(0, 9) < 7)
         a = crt_pkg::ID_W'($urandom_range(0, sb.assigned + 2));
      send_req(act, a, b, $urandom_range(0, 7) == 0);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // response side
   initial begin : rsp_side
      int                 gap;
      relabel_result_type got;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.value_a     = rsp_value_a;
         got.value_b     = rsp_value_b;
         got.newly_added = rsp_newly_added;
         got.invalid     = rsp_invalid;
         got.item_count  = rsp_item_count;
         got.batch_end   = rsp_batch_end_out;
         sb.check_result(got);
      end
   end

   // watchdog on cycles without any handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int                       seg;
      int                       i;
      int                       k;
      logic [crt_pkg::ID_W-1:0] base;
      sb = new();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_action    <= crt_pkg::ACT_INSERT;
      req_id_a      <= '0;
      req_id_b      <= '0;
      req_batch_end <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, repeats, absent ids, clear and reuse
      send_req(crt_pkg::ACT_REVERSE, 16'h0000, 16'hFFFF, 1'b0);
      send_req(crt_pkg::ACT_MAP,     16'h0000, 16'hFFFF, 1'b1);
      send_req(crt_pkg::ACT_INSERT,  16'hFFFF, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  16'h0000, 16'hFFFF, 1'b1);
      send_req(crt_pkg::ACT_INSERT,  16'hFFFF, 16'hFFFF, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  16'h5A5A, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  16'hA5A5, 16'h0000, 1'b1);
      send_req(crt_pkg::ACT_MAP,     16'hFFFF, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_MAP,     16'h1234, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_MAP,     16'h0000, 16'h4321, 1'b1);
      send_req(crt_pkg::ACT_MAP,     16'hA5A5, 16'h5A5A, 1'b0);
      send_req(crt_pkg::ACT_REVERSE, 16'h0000, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_REVERSE, 16'h0003, 16'hFFFF, 1'b0);
      send_req(crt_pkg::ACT_REVERSE, 16'h0004, 16'h0000, 1'b1);
      send_req(crt_pkg::ACT_REVERSE, 16'hFFFF, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_CLEAR,   16'hBEEF, 16'hCAFE, 1'b1);
      send_req(crt_pkg::ACT_MAP,     16'hFFFF, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_REVERSE, 16'h0000, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  16'h0000, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  16'h5A5A, 16'h0000, 1'b1);
      send_req(crt_pkg::ACT_REVERSE, 16'h0001, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_CLEAR,   16'h0000, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_CLEAR,   16'hFFFF, 16'hFFFF, 1'b1);
      send_req(crt_pkg::ACT_INSERT,  16'h8001, 16'h7FFE, 1'b0);
      wait_results_done();

      // random segments with their own pool and idling pattern
      for (seg = 0; seg < SEGMENTS; seg++) begin
         base = crt_pkg::ID_W'($urandom);
         for (k = 0; k < 64; k++)
            id_pool[k] = (k < 48) ? crt_pkg::ID_W'(base + k) : crt_pkg::ID_W'($urandom);
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         // long response stall while requests keep coming
         if (seg == 1 || seg == 7) begin
            req_gap_max = 0;
            hold_rsp    = 1'b1;
         end
         for (i = 0; i < SEG_ITEMS; i++) send_random();
      end
      wait_results_done();

      // clear, probe a fresh table, clear it again and probe once more
      req_gap_max = 14;
      rsp_gap_max = 14;
      send_req(crt_pkg::ACT_CLEAR,   16'h0000, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  16'h1234, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  crt_pkg::ID_W'($urandom), 16'h0000, 1'b1);
      send_req(crt_pkg::ACT_REVERSE, 16'hFFFF, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_REVERSE, 16'h0000, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_MAP,     16'hFFFF, 16'h0000, 1'b1);
      send_req(crt_pkg::ACT_MAP,     crt_pkg::ID_W'($urandom), crt_pkg::ID_W'($urandom),
               1'b0);
      send_req(crt_pkg::ACT_CLEAR,   16'hFFFF, 16'hFFFF, 1'b1);
      send_req(crt_pkg::ACT_MAP,     16'h0000, 16'hFFFF, 1'b0);
      send_req(crt_pkg::ACT_INSERT,  16'h0042, 16'h0000, 1'b0);
      send_req(crt_pkg::ACT_REVERSE, 16'h0000, 16'h0000, 1'b1);
      wait_results_done();

      repeat (40) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
